FILE: rtl/core/acf_pkg.sv
// ----------------------------------------------------------------------------
// acf_pkg
// Shared constants, arctangent table and saturation helper for the
// attitude complementary filter.
// ----------------------------------------------------------------------------
package acf_pkg;

	localparam int ATAN_ITERATIONS_DEF = 16;
	localparam int ATAN_TABLE_LEN      = 24;
	localparam int ITER_CNT_W          = 5;
	localparam int WIDE_W              = 52;
	localparam logic [15:0] BLEND_RESET = 16'd6554;

	// 180 degrees in Q15.16
	localparam logic signed [31:0] ANGLE_180 = 32'sd11796480;

	// atan(2^-i) in Q.16 degrees
	function automatic logic signed [31:0] atan_entry(input logic [ITER_CNT_W-1:0] idx);
		logic signed [31:0] v;
		case (idx)
			5'd0:    v = 32'sd2949120;
			5'd1:    v = 32'sd1740967;
			5'd2:    v = 32'sd919879;
			5'd3:    v = 32'sd466945;
			5'd4:    v = 32'sd234379;
			5'd5:    v = 32'sd117304;
			5'd6:    v = 32'sd58666;
			5'd7:    v = 32'sd29335;
			5'd8:    v = 32'sd14668;
			5'd9:    v = 32'sd7334;
			5'd10:   v = 32'sd3667;
			5'd11:   v = 32'sd1833;
			5'd12:   v = 32'sd917;
			5'd13:   v = 32'sd458;
			5'd14:   v = 32'sd229;
			5'd15:   v = 32'sd115;
			5'd16:   v = 32'sd57;
			5'd17:   v = 32'sd29;
			5'd18:   v = 32'sd14;
			5'd19:   v = 32'sd7;
			5'd20:   v = 32'sd4;
			5'd21:   v = 32'sd2;
			5'd22:   v = 32'sd1;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

	// clamp a wide signed value to the int32 range
	function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [31:0] r;
		if (v > $signed({{(WIDE_W-31){1'b0}}, {31{1'b1}}})) begin
			r = 32'sh7FFFFFFF;
		end else if (v < $signed({{(WIDE_W-31){1'b1}}, {31{1'b0}}})) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/acf_cordic.sv
// ----------------------------------------------------------------------------
// acf_cordic
// Iterative CORDIC atan2 in vectoring mode, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module acf_cordic #(
	parameter int ITERS = acf_pkg::ATAN_ITERATIONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] y_in,
	input  logic signed [15:0] x_in,
	output logic               done,
	output logic signed [31:0] angle
);

	localparam int NITER = (ITERS > acf_pkg::ATAN_TABLE_LEN) ? acf_pkg::ATAN_TABLE_LEN : ITERS;
	localparam logic [acf_pkg::ITER_CNT_W-1:0] CNT_LAST = acf_pkg::ITER_CNT_W'(NITER - 1);

	logic signed [33:0] x_q, y_q;
	logic signed [31:0] z_q;
	logic [acf_pkg::ITER_CNT_W-1:0] cnt_q;
	logic busy_q, done_q, zero_q;

	logic signed [33:0] xe, ye, x0, y0, xs, ys;
	logic signed [31:0] z0, tab;

	always_comb begin
		xe  = {{18{x_in[15]}}, x_in};
		ye  = {{18{y_in[15]}}, y_in};
		x0  = x_in[15] ? -xe : xe;
		y0  = x_in[15] ? -ye : ye;
		if (!x_in[15]) begin
			z0 = 32'sd0;
		end else if (y_in[15]) begin
			z0 = -acf_pkg::ANGLE_180;
		end else begin
			z0 = acf_pkg::ANGLE_180;
		end
		xs  = x_q >>> cnt_q;
		ys  = y_q >>> cnt_q;
		tab = acf_pkg::atan_entry(cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x0 <<< 14;
			y_q    <= y0 <<< 14;
			z_q    <= z0;
			zero_q <= (x_in == 16'sd0) && (y_in == 16'sd0);
		end else if (busy_q) begin
			if (!y_q[33]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - tab;
			end
		end
	end

	assign done  = done_q;
	assign angle = zero_q ? 32'sd0 : z_q;

endmodule

FILE: rtl/core/acf_rdiv.sv
// ----------------------------------------------------------------------------
// acf_rdiv
// Gyro increment rate*ms*4096/1000, rounded half away from zero, by a
// bit-serial restoring divider (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module acf_rdiv (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] rate,
	input  logic [15:0]        ms,
	output logic               done,
	output logic signed [35:0] inc
);

	localparam int DW = 44;
	localparam logic [5:0] CNT_LAST = 6'(DW - 1);

	logic [DW-1:0] dq_q;
	logic [9:0]    rem_q;
	logic [5:0]    cnt_q;
	logic          busy_q, done_q, neg_q;

	logic [15:0] mag_r;
	logic [31:0] prod;
	logic [10:0] trial;
	logic        ge;
	logic signed [35:0] q;

	always_comb begin
		mag_r = rate[15] ? 16'(-rate) : 16'(rate);
		prod  = mag_r * ms;
		trial = {rem_q, dq_q[DW-1]};
		ge    = (trial >= 11'd1000);
		q     = {1'b0, dq_q[34:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= {prod, 12'd0} + 44'd500;
			rem_q <= '0;
			neg_q <= rate[15];
		end else if (busy_q) begin
			rem_q <= ge ? 10'(trial - 11'd1000) : trial[9:0];
			dq_q  <= {dq_q[DW-2:0], ge};
		end
	end

	assign done = done_q;
	assign inc  = neg_q ? -q : q;

endmodule

FILE: rtl/core/acf_smac.sv
// ----------------------------------------------------------------------------
// acf_smac
// Serial blend: ((65536-w)*pred + w*acc + 32768) >>> 16, saturated.
// One weight bit per cycle, shift-and-add.
// ----------------------------------------------------------------------------
module acf_smac (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [15:0]        weight,
	input  logic signed [31:0] pred,
	input  logic signed [31:0] acc,
	output logic               done,
	output logic signed [31:0] result
);

	localparam logic [4:0] CNT_LAST = 5'd16;

	logic signed [50:0] mp_q, ma_q, sum_q;
	logic [16:0] wc_q, wa_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;

	logic signed [50:0] addp, adda;
	logic signed [acf_pkg::WIDE_W-1:0] rnd;

	always_comb begin
		addp = wc_q[0] ? mp_q : 51'sd0;
		adda = wa_q[0] ? ma_q : 51'sd0;
		rnd  = ($signed({sum_q[50], sum_q}) + 52'sd32768) >>> 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mp_q  <= {{19{pred[31]}}, pred};
			ma_q  <= {{19{acc[31]}}, acc};
			wc_q  <= 17'h10000 - {1'b0, weight};
			wa_q  <= {1'b0, weight};
			sum_q <= '0;
		end else if (busy_q) begin
			sum_q <= sum_q + addp + adda;
			mp_q  <= mp_q <<< 1;
			ma_q  <= ma_q <<< 1;
			wc_q  <= wc_q >> 1;
			wa_q  <= wa_q >> 1;
		end
	end

	assign done   = done_q;
	assign result = acf_pkg::sat32(rnd);

endmodule

FILE: rtl/core/attitude_complementary_filter_unit.sv
// ----------------------------------------------------------------------------
// attitude_complementary_filter_unit
// Pitch/roll complementary filter with yaw integration, Q15.16 degrees.
// ----------------------------------------------------------------------------
//
//   channel   dir   fields (low bit up)                               word
//   s_*       in    accel_x, accel_y, accel_z, rate_x, rate_y,       112 bits
//                   rate_z, elapsed_ms
//   m_*       out   pitch_angle, roll_angle, yaw_angle                96 bits
//   APB       in    blend_weight at bits 15:0                         32 bits
//
// One word at a time. The next input can be accepted once the result is
// loaded into the output register. The shared CORDIC runs pitch then roll,
// N = min(ATAN_ITERATIONS, 24) iterations each, while the 44-step gyro
// dividers run alongside, then the serial blender takes 17 steps each for
// pitch and roll. Reset clears all angles and loads blend_weight with 0.1.
// A result waiting on m_tready does not close the input; the next result is
// held back until it is taken.
// ----------------------------------------------------------------------------
module attitude_complementary_filter_unit #(
	parameter int ATAN_ITERATIONS = acf_pkg::ATAN_ITERATIONS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, elapsed_ms
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,
	// pitch_angle, roll_angle, yaw_angle
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ATAN_P = 3'd1;
	localparam logic [2:0] S_ATAN_R = 3'd2;
	localparam logic [2:0] S_WAIT   = 3'd3;
	localparam logic [2:0] S_MAC_P  = 3'd4;
	localparam logic [2:0] S_MAC_R  = 3'd5;
	localparam logic [2:0] S_OUT    = 3'd6;

	logic [2:0]  state_q;
	logic [15:0] weight_q;
	logic signed [31:0] pitch_q, roll_q, yaw_q, accp_q, accr_q;
	logic signed [15:0] ay_q, az_q;
	logic        divdone_q, m_tvalid_q;
	logic [95:0] m_tdata_q;

	logic accept, cfg_wr;
	logic cor_start, cor_done;
	logic signed [15:0] cor_y, cor_x;
	logic signed [31:0] cor_z;
	logic dx_done, dy_done, dz_done;
	logic signed [35:0] inc_x, inc_y, inc_z;
	logic mac_start, mac_done;
	logic signed [31:0] mac_pred, mac_acc, mac_res;
	logic signed [31:0] pred_p, pred_r, yaw_n;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && !paddr[2];
	assign prdata   = paddr[2] ? 32'd0 : {16'd0, weight_q};
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// pitch on accept, roll once pitch is done
	assign cor_start = accept || (state_q == S_ATAN_P && cor_done);
	assign cor_y     = accept ? $signed(s_tdata[15:0]) : ay_q;
	assign cor_x     = accept ? $signed(s_tdata[47:32]) : az_q;

	always_comb begin
		pred_p = acf_pkg::sat32({{20{pitch_q[31]}}, pitch_q} + {{16{inc_y[35]}}, inc_y});
		pred_r = acf_pkg::sat32({{20{roll_q[31]}}, roll_q} + {{16{inc_x[35]}}, inc_x});
		yaw_n  = acf_pkg::sat32({{20{yaw_q[31]}}, yaw_q} + {{16{inc_z[35]}}, inc_z});
	end

	assign mac_start = (state_q == S_WAIT && divdone_q) || (state_q == S_MAC_P && mac_done);
	assign mac_pred  = (state_q == S_WAIT) ? pred_p : pred_r;
	assign mac_acc   = (state_q == S_WAIT) ? accp_q : accr_q;

	acf_cordic #(.ITERS(ATAN_ITERATIONS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start),
		.y_in(cor_y), .x_in(cor_x), .done(cor_done), .angle(cor_z)
	);

	acf_rdiv u_div_x (
		.clk(clk), .arst_n(arst_n), .start(accept), .rate($signed(s_tdata[63:48])),
		.ms(s_tdata[111:96]), .done(dx_done), .inc(inc_x)
	);

	acf_rdiv u_div_y (
		.clk(clk), .arst_n(arst_n), .start(accept), .rate($signed(s_tdata[79:64])),
		.ms(s_tdata[111:96]), .done(dy_done), .inc(inc_y)
	);

	acf_rdiv u_div_z (
		.clk(clk), .arst_n(arst_n), .start(accept), .rate($signed(s_tdata[95:80])),
		.ms(s_tdata[111:96]), .done(dz_done), .inc(inc_z)
	);

	acf_smac u_mac (
		.clk(clk), .arst_n(arst_n), .start(mac_start), .weight(weight_q),
		.pred(mac_pred), .acc(mac_acc), .done(mac_done), .result(mac_res)
	);

	// hold roll operands for the second CORDIC pass
	always_ff @(posedge clk) begin
		if (accept) begin
			ay_q <= $signed(s_tdata[31:16]);
			az_q <= $signed(s_tdata[47:32]);
		end
		if (state_q == S_ATAN_P && cor_done) begin
			accp_q <= -cor_z;
		end
		if (state_q == S_ATAN_R && cor_done) begin
			accr_q <= cor_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			weight_q   <= acf_pkg::BLEND_RESET;
			pitch_q    <= '0;
			roll_q     <= '0;
			yaw_q      <= '0;
			divdone_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (cfg_wr) begin
				weight_q <= pwdata[15:0];
			end
			// drop a taken word unless a new one is loaded in this cycle
			if (m_tvalid_q && m_tready && state_q != S_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			// the three dividers run in lockstep
			if (accept) begin
				divdone_q <= 1'b0;
			end else if (dx_done && dy_done && dz_done) begin
				divdone_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_ATAN_P;
					end
				end
				S_ATAN_P: begin
					if (cor_done) begin
						state_q <= S_ATAN_R;
					end
				end
				S_ATAN_R: begin
					if (cor_done) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (divdone_q) begin
						yaw_q   <= yaw_n;
						state_q <= S_MAC_P;
					end
				end
				S_MAC_P: begin
					if (mac_done) begin
						pitch_q <= mac_res;
						state_q <= S_MAC_R;
					end
				end
				S_MAC_R: begin
					if (mac_done) begin
						roll_q  <= mac_res;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {yaw_q, roll_q, pitch_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// an accepted word closes the input until its result is built
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input accepted again right after a word");

	a_cordic_in_atan: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == S_ATAN_P || state_q == S_ATAN_R))
		else $error("CORDIC finished outside the atan phases");

	a_div_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dx_done |-> (state_q != S_IDLE && state_q != S_OUT))
		else $error("gyro divider finished with no word in flight");

	a_mac_in_blend: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == S_MAC_P || state_q == S_MAC_R))
		else $error("blend finished outside the blend phases");

endmodule
